// File: rtl/core/trap_and_interrupt_unit_assert.svh
// Assertion helpers for the trap and interrupt unit.
// Both forms sample on clk_i and are switched off while rst_ni is low.
`ifndef TRAP_AND_INTERRUPT_UNIT_ASSERT_SVH
`define TRAP_AND_INTERRUPT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TIU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("trap_and_interrupt_unit: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TIU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("trap_and_interrupt_unit: assertion failed");

`endif

// File: rtl/core/tiu_pkg.sv
`default_nettype none

package tiu_pkg;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_TRAP    = 2'd0,
    OP_SET_IRQ = 2'd1,
    OP_QUERY   = 2'd2,
    OP_WRITE   = 2'd3
  } tiu_op_e;

  // Configuration register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_MTVEC   = 3'd0,
    REG_STVEC   = 3'd1,
    REG_IE      = 3'd2,
    REG_EDELEG  = 3'd3,
    REG_IDELEG  = 3'd4
  } tiu_reg_e;

  // Reported interrupt, highest priority first.
  typedef enum logic [2:0] {
    IRQ_NONE = 3'd0,
    IRQ_MEI  = 3'd1,
    IRQ_MSI  = 3'd2,
    IRQ_MTI  = 3'd3,
    IRQ_SEI  = 3'd4,
    IRQ_SSI  = 3'd5,
    IRQ_STI  = 3'd6
  } tiu_irq_e;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned ADDR_W    = 5;

  // Privilege levels.
  localparam logic [1:0] PRIV_U     = 2'd0;
  localparam logic [1:0] PRIV_S     = 2'd1;
  localparam logic [1:0] PRIV_KEEP  = 2'd2;
  localparam logic [1:0] PRIV_M     = 2'd3;

  // mstatus bit positions.
  localparam int unsigned ST_SIE    = 1;
  localparam int unsigned ST_MIE    = 3;
  localparam int unsigned ST_SPIE   = 5;
  localparam int unsigned ST_MPIE   = 7;
  localparam int unsigned ST_SPP    = 8;
  localparam int unsigned ST_MPP_LO = 11;
  localparam int unsigned ST_MPP_HI = 12;

  // Pending bit positions.
  localparam int unsigned IP_SSI    = 1;
  localparam int unsigned IP_MSI    = 3;
  localparam int unsigned IP_MTI    = 7;
  localparam int unsigned IP_SEI    = 9;
  localparam int unsigned IP_MEI    = 11;

  localparam logic [XLEN-1:0] STATUS_RESET = 32'h0000_2000;
  localparam logic [1:0]      VEC_MODE_VECTORED = 2'b01;

  // Configuration registers as seen by the trap logic.
  typedef struct packed {
    logic [XLEN-1:0] mtvec;
    logic [XLEN-1:0] stvec;
    logic [XLEN-1:0] ie;
    logic [XLEN-1:0] edeleg;
    logic [XLEN-1:0] ideleg;
  } tiu_cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/tiu_cfg_regs.sv
`default_nettype none

module tiu_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tiu_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [tiu_pkg::XLEN-1:0]      pwdata,
  output logic      [tiu_pkg::XLEN-1:0]      prdata,
  output logic                               pready,
  output tiu_pkg::tiu_cfg_t                  cfg_o
);
  import tiu_pkg::*;

  tiu_cfg_t cfg_q;
  tiu_cfg_t cfg_d;
  tiu_reg_e reg_idx;
  logic     wr_en;

  assign reg_idx = tiu_reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write decode: addresses past the last register are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_MTVEC:  cfg_d.mtvec  = pwdata;
        REG_STVEC:  cfg_d.stvec  = pwdata;
        REG_IE:     cfg_d.ie     = pwdata;
        REG_EDELEG: cfg_d.edeleg = pwdata;
        REG_IDELEG: cfg_d.ideleg = pwdata;
        default:    cfg_d        = cfg_q;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      REG_MTVEC:  prdata = cfg_q.mtvec;
      REG_STVEC:  prdata = cfg_q.stvec;
      REG_IE:     prdata = cfg_q.ie;
      REG_EDELEG: prdata = cfg_q.edeleg;
      REG_IDELEG: prdata = cfg_q.ideleg;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/trap_and_interrupt_unit.sv
// Trap and interrupt unit for an RV32 hart with M, S and U levels.
// Requests arrive on the in_valid_i/in_ready_o channel with an operation
// code: take a trap, raise or lower one pending interrupt line, query, or
// load privilege and mstatus. Every request yields exactly one result on the
// out_valid_o/out_ready_i channel: the handler PC and target level for a
// trap, the highest-priority takeable interrupt, and the architectural
// state after the request.
// An accepted request's result is registered and shows from the next cycle on.
// One request per cycle is sustained while the receiver keeps taking
// results; the single result register is the only stage, and it is reloaded
// in the same cycle that its result is taken.
// When the receiver stalls, the result holds and in_ready_o drops until the
// result is taken; no request is lost or repeated.
// Vector bases, enables and delegation masks are written over APB (pready
// is always high); the user must do so only while no request is in flight;
// the block does not enforce this. Reset puts M mode and mstatus 0x2000 and
// clears pending bits, saved trap state, configuration registers and output.
`default_nettype none
`include "trap_and_interrupt_unit_assert.svh"

module trap_and_interrupt_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tiu_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tiu_pkg::XLEN-1:0]   pwdata,
  output logic      [tiu_pkg::XLEN-1:0]   prdata,
  output logic                            pready,
  // Request channel
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 op_i,
  input  wire logic [tiu_pkg::XLEN-1:0]   cause_i,
  input  wire logic [tiu_pkg::XLEN-1:0]   trap_value_i,
  input  wire logic [tiu_pkg::XLEN-1:0]   current_pc_i,
  input  wire logic                       irq_level_i,
  input  wire logic [1:0]                 new_priv_i,
  input  wire logic [tiu_pkg::XLEN-1:0]   new_status_i,
  // Result channel
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [tiu_pkg::XLEN-1:0]   next_pc_o,
  output logic                            to_supervisor_o,
  output logic      [2:0]                 pending_o,
  output logic      [1:0]                 privilege_o,
  output logic      [tiu_pkg::XLEN-1:0]   status_o,
  output logic      [tiu_pkg::XLEN-1:0]   pending_bits_o,
  output logic      [tiu_pkg::XLEN-1:0]   m_epc_o,
  output logic      [tiu_pkg::XLEN-1:0]   m_cause_o,
  output logic      [tiu_pkg::XLEN-1:0]   m_tval_o,
  output logic      [tiu_pkg::XLEN-1:0]   s_epc_o,
  output logic      [tiu_pkg::XLEN-1:0]   s_cause_o,
  output logic      [tiu_pkg::XLEN-1:0]   s_tval_o
);
  import tiu_pkg::*;

  // Highest-priority interrupt that the given state would take.
  function automatic logic [2:0] irq_select(
    input logic [XLEN-1:0] pend,
    input logic [XLEN-1:0] ie,
    input logic [XLEN-1:0] ideleg,
    input logic [1:0]      priv,
    input logic [XLEN-1:0] status
  );
    logic [XLEN-1:0] act;
    tiu_irq_e        code;
    act  = pend & ie;
    code = IRQ_NONE;
    if (priv == PRIV_M && !status[ST_MIE]) begin
      act = '0;
    end else if (priv == PRIV_M) begin
      act = act & ~ideleg;
    end else if (priv == PRIV_S && !status[ST_SIE]) begin
      act = act & ~ideleg;
    end
    if (act[IP_MEI]) begin
      code = IRQ_MEI;
    end else if (act[IP_MSI]) begin
      code = IRQ_MSI;
    end else if (act[IP_MTI]) begin
      code = IRQ_MTI;
    end else if (act[IP_SEI]) begin
      code = IRQ_SEI;
    end else if (act[IP_SSI]) begin
      code = IRQ_SSI;
    end else if (act != '0) begin
      code = IRQ_STI;
    end
    return code;
  endfunction

  tiu_cfg_t        cfg;

  // Architectural state.
  logic [1:0]      priv_q, priv_d;
  logic [XLEN-1:0] status_q, status_d;
  logic [XLEN-1:0] pend_q, pend_d;
  logic [XLEN-1:0] mepc_q, mepc_d, mcause_q, mcause_d, mtval_q, mtval_d;
  logic [XLEN-1:0] sepc_q, sepc_d, scause_q, scause_d, stval_q, stval_d;

  // Result register.
  logic            out_valid_q;
  logic [XLEN-1:0] npc_q, npc_d;
  logic            to_s_q, to_s_d;
  logic [2:0]      irq_q, irq_d;

  logic            in_acc;
  logic            out_acc;
  tiu_op_e         op;
  logic [XLEN-1:0] deleg_word;
  logic [XLEN-1:0] vec;
  logic [XLEN-1:0] vec_base;
  logic            delegated;
  logic            trap_level_ok;

  tiu_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The result register is refilled in the cycle its contents are taken.
  assign out_acc    = out_valid_q && out_ready_i;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign op         = tiu_op_e'(op_i);

  // Delegation decision: only from S or U, and only for codes below 32.
  assign deleg_word = cause_i[XLEN-1] ? cfg.ideleg : cfg.edeleg;
  assign delegated  = (priv_q == PRIV_U || priv_q == PRIV_S)
                      && (cause_i[XLEN-2:5] == '0)
                      && deleg_word[cause_i[4:0]];

  // Handler address; vectored mode only offsets interrupts.
  assign vec = delegated ? cfg.stvec : cfg.mtvec;
  always_comb begin
    vec_base = {vec[XLEN-1:2], 2'b00};
    if (vec[1:0] == VEC_MODE_VECTORED && cause_i[XLEN-1]) begin
      vec_base = vec_base + {cause_i[XLEN-3:0], 2'b00};
    end
  end

  // State update for one request.
  always_comb begin
    priv_d   = priv_q;
    status_d = status_q;
    pend_d   = pend_q;
    mepc_d   = mepc_q;
    mcause_d = mcause_q;
    mtval_d  = mtval_q;
    sepc_d   = sepc_q;
    scause_d = scause_q;
    stval_d  = stval_q;
    npc_d    = '0;
    to_s_d   = 1'b0;
    case (op)
      OP_TRAP: begin
        npc_d = vec_base;
        if (delegated) begin
          to_s_d            = 1'b1;
          sepc_d            = current_pc_i;
          scause_d          = cause_i;
          stval_d           = trap_value_i;
          status_d[ST_SPIE] = status_q[ST_SIE];
          status_d[ST_SIE]  = 1'b0;
          status_d[ST_SPP]  = (priv_q == PRIV_S);
          priv_d            = PRIV_S;
        end else begin
          mepc_d                        = current_pc_i;
          mcause_d                      = cause_i;
          mtval_d                       = trap_value_i;
          status_d[ST_MPIE]             = status_q[ST_MIE];
          status_d[ST_MIE]              = 1'b0;
          status_d[ST_MPP_HI:ST_MPP_LO] = priv_q;
          priv_d                        = PRIV_M;
        end
      end
      OP_SET_IRQ: begin
        pend_d[cause_i[4:0]] = irq_level_i;
      end
      OP_QUERY: begin
        priv_d = priv_q;
      end
      OP_WRITE: begin
        status_d = new_status_i;
        if (new_priv_i != PRIV_KEEP) begin
          priv_d = new_priv_i;
        end
      end
      default: begin
        priv_d = priv_q;
      end
    endcase
    irq_d = irq_select(pend_d, cfg.ie, cfg.ideleg, priv_d, status_d);
  end

  // State registers advance only on an accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      priv_q   <= PRIV_M;
      status_q <= STATUS_RESET;
      pend_q   <= '0;
      mepc_q   <= '0;
      mcause_q <= '0;
      mtval_q  <= '0;
      sepc_q   <= '0;
      scause_q <= '0;
      stval_q  <= '0;
    end else if (in_acc) begin
      priv_q   <= priv_d;
      status_q <= status_d;
      pend_q   <= pend_d;
      mepc_q   <= mepc_d;
      mcause_q <= mcause_d;
      mtval_q  <= mtval_d;
      sepc_q   <= sepc_d;
      scause_q <= scause_d;
      stval_q  <= stval_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  // Per-request result fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      npc_q  <= '0;
      to_s_q <= 1'b0;
      irq_q  <= '0;
    end else if (in_acc) begin
      npc_q  <= npc_d;
      to_s_q <= to_s_d;
      irq_q  <= irq_d;
    end
  end

  // The state cannot move while a result waits, so the state registers
  // themselves carry the after-request state fields of the result.
  assign out_valid_o     = out_valid_q;
  assign next_pc_o       = npc_q;
  assign to_supervisor_o = to_s_q;
  assign pending_o       = irq_q;
  assign privilege_o     = priv_q;
  assign status_o        = status_q;
  assign pending_bits_o  = pend_q;
  assign m_epc_o         = mepc_q;
  assign m_cause_o       = mcause_q;
  assign m_tval_o        = mtval_q;
  assign s_epc_o         = sepc_q;
  assign s_cause_o       = scause_q;
  assign s_tval_o        = stval_q;

  // The level held now agrees with the target reported for the last trap.
  assign trap_level_ok = to_s_q ? (priv_q == PRIV_S) : (priv_q == PRIV_M);

  // A trap lands in S exactly when reported so, otherwise in M.
  `TIU_ASSERT_NEXT(a_trap_target, in_acc && op == OP_TRAP, out_valid_q && trap_level_ok)
  // Requests other than traps report no handler address.
  `TIU_ASSERT_NEXT(a_no_trap_pc, in_acc && op != OP_TRAP, npc_q == '0 && !to_s_q)
  // A query leaves all state as it was.
  `TIU_ASSERT_NEXT(a_query_keeps, in_acc && op == OP_QUERY, $stable({status_q, priv_q, pend_q}))
  // An empty result register never blocks requests.
  `TIU_ASSERT_IMPL(a_ready_empty, !out_valid_q, in_ready_o)
  // State is frozen while a result is stalled.
  `TIU_ASSERT_NEXT(a_stall_freeze, !in_ready_o, $stable({status_q, pend_q, priv_q}))

endmodule

`default_nettype wire

// File: verif/trap_and_interrupt_unit_checker.sv
module trap_and_interrupt_unit_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration port, observed only
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tiu_pkg::ADDR_W-1:0]   paddr,
  input  logic [tiu_pkg::XLEN-1:0]     pwdata,
  input  logic                         pready,
  // Request channel
  input  logic                         in_valid_i,
  input  logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic [tiu_pkg::XLEN-1:0]     cause_i,
  input  logic [tiu_pkg::XLEN-1:0]     trap_value_i,
  input  logic [tiu_pkg::XLEN-1:0]     current_pc_i,
  input  logic                         irq_level_i,
  input  logic [1:0]                   new_priv_i,
  input  logic [tiu_pkg::XLEN-1:0]     new_status_i,
  // Result channel
  input  logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  logic [tiu_pkg::XLEN-1:0]     next_pc_o,
  input  logic                         to_supervisor_o,
  input  logic [2:0]                   pending_o,
  input  logic [1:0]                   privilege_o,
  input  logic [tiu_pkg::XLEN-1:0]     status_o,
  input  logic [tiu_pkg::XLEN-1:0]     pending_bits_o,
  input  logic [tiu_pkg::XLEN-1:0]     m_epc_o,
  input  logic [tiu_pkg::XLEN-1:0]     m_cause_o,
  input  logic [tiu_pkg::XLEN-1:0]     m_tval_o,
  input  logic [tiu_pkg::XLEN-1:0]     s_epc_o,
  input  logic [tiu_pkg::XLEN-1:0]     s_cause_o,
  input  logic [tiu_pkg::XLEN-1:0]     s_tval_o,
  // Summary for the testbench top
  output int                           outstanding_o,
  output int                           fail_count_o
);
  import tiu_pkg::*;

  // What one request is expected to produce.
  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    logic            to_supervisor;
    tiu_irq_e        pending;
    logic [1:0]      privilege;
    logic [XLEN-1:0] status;
    logic [XLEN-1:0] pending_bits;
    logic [XLEN-1:0] m_epc;
    logic [XLEN-1:0] m_cause;
    logic [XLEN-1:0] m_tval;
    logic [XLEN-1:0] s_epc;
    logic [XLEN-1:0] s_cause;
    logic [XLEN-1:0] s_tval;
  } outcome_t;

  // Mirror of the hart state and of the configuration registers.
  tiu_cfg_t        cfg;
  logic [1:0]      hart_priv;
  logic [XLEN-1:0] mstatus;
  logic [XLEN-1:0] mip;
  logic [XLEN-1:0] mepc, mcause, mtval;
  logic [XLEN-1:0] sepc, scause, stval;

  outcome_t expected_outcomes[$];
  int       mismatch_count;

  assign fail_count_o = mismatch_count;

  // Highest-priority interrupt that the hart could take in its current state.
  function automatic tiu_irq_e takeable_irq();
    logic [XLEN-1:0] active;
    active = mip & cfg.ie;
    if (active == '0) return IRQ_NONE;
    if (hart_priv == PRIV_M && !mstatus[ST_MIE]) return IRQ_NONE;
    // Delegated lines are out of reach in M and in S with interrupts off.
    if (hart_priv == PRIV_M || (hart_priv == PRIV_S && !mstatus[ST_SIE])) begin
      active &= ~cfg.ideleg;
    end
    if (active == '0) return IRQ_NONE;
    if (active[IP_MEI]) return IRQ_MEI;
    if (active[IP_MSI]) return IRQ_MSI;
    if (active[IP_MTI]) return IRQ_MTI;
    if (active[IP_SEI]) return IRQ_SEI;
    if (active[IP_SSI]) return IRQ_SSI;
    return IRQ_STI;
  endfunction

  // Applies one request to the mirrored state and returns its result.
  function automatic outcome_t apply_request(tiu_op_e op, logic [XLEN-1:0] cause,
                                             logic [XLEN-1:0] tval, logic [XLEN-1:0] pc,
                                             logic level, logic [1:0] priv_req,
                                             logic [XLEN-1:0] status_req);
    outcome_t        res;
    logic [XLEN-1:0] vec;
    logic [30:0]     code;
    logic            is_irq;
    logic            to_s;
    res = '0;
    case (op)
      OP_TRAP: begin
        is_irq = cause[XLEN-1];
        code   = cause[30:0];
        // Only traps from S or U with a code below 32 can be delegated.
        to_s = (hart_priv <= PRIV_S) && (code < 31'd32) &&
               (is_irq ? cfg.ideleg[code[4:0]] : cfg.edeleg[code[4:0]]);
        if (to_s) begin
          sepc = pc;
          scause = cause;
          stval = tval;
          mstatus[ST_SPIE] = mstatus[ST_SIE];
          mstatus[ST_SIE]  = 1'b0;
          mstatus[ST_SPP]  = (hart_priv == PRIV_S);
          hart_priv = PRIV_S;
          vec = cfg.stvec;
        end else begin
          mepc = pc;
          mcause = cause;
          mtval = tval;
          mstatus[ST_MPIE] = mstatus[ST_MIE];
          mstatus[ST_MIE]  = 1'b0;
          mstatus[ST_MPP_HI:ST_MPP_LO] = hart_priv;
          hart_priv = PRIV_M;
          vec = cfg.mtvec;
        end
        // Vectored entry only for interrupts; the offset wraps at 32 bits.
        res.next_pc = {vec[XLEN-1:2], 2'b00};
        if (vec[1:0] == VEC_MODE_VECTORED && is_irq) begin
          res.next_pc = res.next_pc + {cause[29:0], 2'b00};
        end
        res.to_supervisor = to_s;
      end
      OP_SET_IRQ: begin
        mip[cause[4:0]] = level;
      end
      OP_WRITE: begin
        mstatus = status_req;
        if (priv_req != PRIV_KEEP) hart_priv = priv_req;
      end
      default: begin
      end
    endcase
    res.pending      = takeable_irq();
    res.privilege    = hart_priv;
    res.status       = mstatus;
    res.pending_bits = mip;
    res.m_epc        = mepc;
    res.m_cause      = mcause;
    res.m_tval       = mtval;
    res.s_epc        = sepc;
    res.s_cause      = scause;
    res.s_tval       = stval;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [XLEN-1:0] exp,
                             input logic [XLEN-1:0] got);
    if (got !== exp) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch in %s: expected %h, got %h", field, exp, got);
      end
    end
  endtask

  task automatic compare_outcome(input outcome_t exp);
    check_field("next_pc", exp.next_pc, next_pc_o);
    check_field("to_supervisor", XLEN'(exp.to_supervisor), XLEN'(to_supervisor_o));
    check_field("pending", XLEN'(exp.pending), XLEN'(pending_o));
    check_field("privilege", XLEN'(exp.privilege), XLEN'(privilege_o));
    check_field("status", exp.status, status_o);
    check_field("pending_bits", exp.pending_bits, pending_bits_o);
    check_field("m_epc", exp.m_epc, m_epc_o);
    check_field("m_cause", exp.m_cause, m_cause_o);
    check_field("m_tval", exp.m_tval, m_tval_o);
    check_field("s_epc", exp.s_epc, s_epc_o);
    check_field("s_cause", exp.s_cause, s_cause_o);
    check_field("s_tval", exp.s_tval, s_tval_o);
  endtask

  // Track register writes, check results, and predict accepted requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg       = '0;
      hart_priv = PRIV_M;
      mstatus   = STATUS_RESET;
      mip       = '0;
      mepc      = '0;
      mcause    = '0;
      mtval     = '0;
      sepc      = '0;
      scause    = '0;
      stval     = '0;
      expected_outcomes.delete();
      mismatch_count = 0;
      outstanding_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_MTVEC:  cfg.mtvec  = pwdata;
          REG_STVEC:  cfg.stvec  = pwdata;
          REG_IE:     cfg.ie     = pwdata;
          REG_EDELEG: cfg.edeleg = pwdata;
          REG_IDELEG: cfg.ideleg = pwdata;
          default: begin
          end
        endcase
      end
      // A result always belongs to an earlier request, so it is checked first.
      if (out_valid_o && out_ready_i) begin
        if (expected_outcomes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result arrived with no request outstanding");
          end
        end else begin
          compare_outcome(expected_outcomes.pop_front());
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_outcomes.push_back(apply_request(tiu_op_e'(op_i), cause_i, trap_value_i,
                                                  current_pc_i, irq_level_i, new_priv_i,
                                                  new_status_i));
      end
      outstanding_o <= expected_outcomes.size();
    end
  end

endmodule

// File: verif/trap_and_interrupt_unit_tb.sv
module trap_and_interrupt_unit_tb;
  import tiu_pkg::*;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [XLEN-1:0]     pwdata = '0;
  logic [XLEN-1:0]     prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          op_i = OP_QUERY;
  logic [XLEN-1:0]     cause_i = '0;
  logic [XLEN-1:0]     trap_value_i = '0;
  logic [XLEN-1:0]     current_pc_i = '0;
  logic                irq_level_i = 1'b0;
  logic [1:0]          new_priv_i = PRIV_KEEP;
  logic [XLEN-1:0]     new_status_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [XLEN-1:0]     next_pc_o;
  logic                to_supervisor_o;
  logic [2:0]          pending_o;
  logic [1:0]          privilege_o;
  logic [XLEN-1:0]     status_o;
  logic [XLEN-1:0]     pending_bits_o;
  logic [XLEN-1:0]     m_epc_o;
  logic [XLEN-1:0]     m_cause_o;
  logic [XLEN-1:0]     m_tval_o;
  logic [XLEN-1:0]     s_epc_o;
  logic [XLEN-1:0]     s_cause_o;
  logic [XLEN-1:0]     s_tval_o;
  int                  requests_in_flight;
  int                  fail_count;

  trap_and_interrupt_unit uut (.*);

  trap_and_interrupt_unit_checker checker_inst (
    .*,
    .outstanding_o(requests_in_flight),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: bursts of ready cycles separated by random stalls.
  initial begin : result_sink
    int burst;
    int stall;
    burst = 0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (burst == 0 && stall == 0) begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
        stall = gap_length();
      end
      if (burst > 0) begin
        out_ready_i <= 1'b1;
        burst--;
      end else begin
        out_ready_i <= 1'b0;
        stall--;
      end
    end
  end

  // Presents one request and returns at the edge where it is accepted.
  task automatic issue(input tiu_op_e op, input logic [XLEN-1:0] cause,
                       input logic [XLEN-1:0] tval, input logic [XLEN-1:0] pc,
                       input logic level, input logic [1:0] priv_req,
                       input logic [XLEN-1:0] status_req);
    in_valid_i   <= 1'b1;
    op_i         <= op;
    cause_i      <= cause;
    trap_value_i <= tval;
    current_pc_i <= pc;
    irq_level_i  <= level;
    new_priv_i   <= priv_req;
    new_status_i <= status_req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic pause(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Holds off new requests until every result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (requests_in_flight != 0);
  endtask

  // One APB write; the caller releases psel after the last one.
  task automatic apb_write(input tiu_reg_e idx, input logic [XLEN-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic program_unit(input logic [XLEN-1:0] mtvec, input logic [XLEN-1:0] stvec,
                              input logic [XLEN-1:0] ie, input logic [XLEN-1:0] edeleg,
                              input logic [XLEN-1:0] ideleg);
    drain();
    repeat (2) @(posedge clk_i);
    apb_write(REG_MTVEC, mtvec);
    apb_write(REG_STVEC, stvec);
    apb_write(REG_IE, ie);
    apb_write(REG_EDELEG, edeleg);
    apb_write(REG_IDELEG, ideleg);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random requests: mostly legal trap codes and the standard interrupt lines,
  // with fully random words mixed in.
  task automatic run_random(input int count);
    tiu_op_e         op;
    logic [XLEN-1:0] cause;
    logic [XLEN-1:0] status_req;
    int              sel;
    int              gap;
    for (int i = 0; i < count; i++) begin
      sel        = $urandom_range(0, 99);
      cause      = $urandom;
      status_req = $urandom;
      if (sel < 35) begin
        op = OP_TRAP;
        if ($urandom_range(0, 9) != 0) begin
          cause = ($urandom_range(0, 1) << 31) | $urandom_range(0, 31);
        end
      end else if (sel < 60) begin
        op = OP_SET_IRQ;
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 4))
            0: cause[4:0] = 5'(IP_SSI);
            1: cause[4:0] = 5'(IP_MSI);
            2: cause[4:0] = 5'(IP_MTI);
            3: cause[4:0] = 5'(IP_SEI);
            default: cause[4:0] = 5'(IP_MEI);
          endcase
        end
      end else if (sel < 70) begin
        op = OP_QUERY;
      end else begin
        op = OP_WRITE;
        // Keep interrupts enabled more often than not.
        status_req[ST_MIE] = ($urandom_range(0, 3) != 0);
        status_req[ST_SIE] = ($urandom_range(0, 3) != 0);
      end
      issue(op, cause, $urandom, $urandom, 1'($urandom_range(0, 1)),
            2'($urandom_range(0, 3)), status_req);
      gap = gap_length();
      if (gap > 0) pause(gap);
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: vectored bases, mtvec near the top of the address space,
    // all exceptions delegated, SSI, STI and SEI delegated.
    program_unit(32'hFFFF_FFF1, 32'h8000_0001, '1, '1, 32'h0000_0222);
    issue(OP_QUERY, '1, '1, '1, 1'b1, PRIV_U, '1);
    // Only the low five bits of the cause select the line.
    issue(OP_SET_IRQ, 32'hFFFF_FFEB, '0, '0, 1'b1, PRIV_M, '0);
    issue(OP_SET_IRQ, 32'h0000_0009, '0, '0, 1'b1, PRIV_M, '0);
    issue(OP_SET_IRQ, 32'h0000_0003, '0, '0, 1'b1, PRIV_M, '0);
    issue(OP_SET_IRQ, 32'h0000_0007, '0, '0, 1'b1, PRIV_M, '0);
    issue(OP_SET_IRQ, 32'h0000_0001, '0, '0, 1'b1, PRIV_M, '0);
    issue(OP_SET_IRQ, 32'h0000_0005, '0, '0, 1'b1, PRIV_M, '0);
    issue(OP_SET_IRQ, 32'h0000_001F, '0, '0, 1'b1, PRIV_M, '0);
    issue(OP_SET_IRQ, 32'h0000_0000, '0, '0, 1'b1, PRIV_M, '0);
    // Status written with the privilege kept.
    issue(OP_WRITE, '0, '0, '0, 1'b0, PRIV_KEEP, '1);
    issue(OP_SET_IRQ, 32'h0000_000B, '0, '0, 1'b0, PRIV_M, '0);
    issue(OP_WRITE, '0, '0, '0, 1'b0, PRIV_U, '0);
    // Delegated exception from U, then a delegated interrupt from S.
    issue(OP_TRAP, 32'h0000_0002, '1, '0, 1'b0, PRIV_M, '0);
    issue(OP_TRAP, 32'h8000_0009, '0, 32'hFFFF_FFFC, 1'b0, PRIV_M, '0);
    issue(OP_WRITE, '0, '0, '0, 1'b0, PRIV_S, '0);
    issue(OP_WRITE, '0, '0, '0, 1'b0, PRIV_S, 32'h0000_0002);
    // Interrupt code above 31 goes to M; the vectored offset wraps.
    issue(OP_TRAP, '1, 32'h1234_5678, 32'h0000_0100, 1'b0, PRIV_M, '0);
    // A trap in M stays in M even when delegated.
    issue(OP_TRAP, 32'h0000_0008, '0, 32'h0000_0200, 1'b0, PRIV_M, '0);
    issue(OP_WRITE, '0, '0, '0, 1'b0, PRIV_U, '0);
    issue(OP_TRAP, 32'h0000_001F, 32'hA5A5_A5A5, 32'h0000_0300, 1'b0, PRIV_M, '0);
    issue(OP_WRITE, '0, '0, '0, 1'b0, PRIV_U, '0);
    issue(OP_TRAP, 32'h0000_0020, 32'h5A5A_5A5A, 32'h0000_0400, 1'b0, PRIV_M, '0);
    issue(OP_TRAP, 32'h8000_0007, '0, 32'h0000_0500, 1'b0, PRIV_M, '0);
    issue(OP_SET_IRQ, 32'h0000_0000, '0, '0, 1'b0, PRIV_M, '0);
    issue(OP_WRITE, '0, '0, '0, 1'b0, PRIV_M, 32'h0000_0008);

    // Random part over several register settings, the extremes first.
    program_unit('0, '0, '0, '0, '0);
    run_random(80);
    program_unit('1, '1, '1, '1, '1);
    run_random(80);
    for (int phase = 0; phase < 4; phase++) begin
      program_unit($urandom, $urandom, $urandom | 32'h0000_0AAA, $urandom, $urandom);
      run_random(85);
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
